// File: rtl/tdrs_pkg.sv
// Package for the two-channel delay relay sequencer.
// Holds transaction structs, register indexes and reset constants.
// No dependencies.
`timescale 1ns / 1ps

package tdrs_pkg;

	// Field widths
	localparam int DELAY_BITS = 16;
	localparam int PHASE_BITS = 8;
	localparam int CFG_INDEX_BITS = 2;

	// Default counter width
	localparam int COUNT_BITS_DEF = 16;

	// Configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_SHORT  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_MEDIUM = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_LONG   = 2'd2;

	// Register reset values
	localparam logic [DELAY_BITS-1:0] DELAY_SHORT_RST  = 16'd500;
	localparam logic [DELAY_BITS-1:0] DELAY_MEDIUM_RST = 16'd1000;
	localparam logic [DELAY_BITS-1:0] DELAY_LONG_RST   = 16'd2000;

	// Phase values with a meaning of their own
	localparam logic [PHASE_BITS-1:0] PHASE_IDLE  = 8'd0;
	localparam logic [PHASE_BITS-1:0] PHASE_ONE   = 8'd1;
	localparam logic [PHASE_BITS-1:0] PHASE_TWO   = 8'd2;
	localparam logic [PHASE_BITS-1:0] PHASE_THREE = 8'd3;

	// Item action codes
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_TICK   = 1'b1;

	// Input transaction
	typedef struct packed {
		logic action;
		logic level_a;
		logic level_b;
		logic key_one_n;
		logic key_two_n;
		logic key_three_n;
	} item_t;

	// Result transaction
	typedef struct packed {
		logic relay_a;
		logic relay_b;
	} result_t;

endpackage

// File: rtl/two_channel_delay_relay_sequencer.sv
// Top level of the two-channel delay relay sequencer.
// Input register, one pass of update logic, state and result registers.
// Depends on tdrs_pkg.
`timescale 1ns / 1ps

//  channel | valid        | stall        | payload
//  --------+--------------+--------------+---------------------------
//  item    | item_valid   | item_stall   | item   (tdrs_pkg::item_t)
//  result  | result_valid | result_stall | result (tdrs_pkg::result_t)
//  config  | cfg_we       | -            | cfg_index, cfg_data
//
// One transaction per clock is sustained while the result is not stalled. A
// transaction is captured in the input register, then updates state and the
// result register when the stage advances; the result is held until taken.
// The input register refills while the result waits; item_stall rises
// only when both are full and result_stall is high. Reset empties both
// registers and loads the state reset values.

module two_channel_delay_relay_sequencer #(
	parameter int COUNT_BITS = tdrs_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  tdrs_pkg::item_t                     item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output tdrs_pkg::result_t                   result,
	input  logic                                cfg_we,
	input  logic [tdrs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [tdrs_pkg::DELAY_BITS-1:0]     cfg_data
);

	// Configuration registers
	logic [tdrs_pkg::DELAY_BITS-1:0] delay_short_q;
	logic [tdrs_pkg::DELAY_BITS-1:0] delay_medium_q;
	logic [tdrs_pkg::DELAY_BITS-1:0] delay_long_q;

	// Sequencer state
	logic [tdrs_pkg::DELAY_BITS-1:0] chosen_q;
	logic [COUNT_BITS-1:0]           count_a_q;
	logic [COUNT_BITS-1:0]           count_b_q;
	logic [tdrs_pkg::PHASE_BITS-1:0] phase_q;
	logic                            prev_a_q;
	logic                            prev_b_q;
	logic                            drive_a_q;
	logic                            drive_b_q;

	// Input stage and result valid
	tdrs_pkg::item_t                 item_s1;
	logic                            valid_s1;
	logic                            result_valid_q;

	// Next-state values
	logic [tdrs_pkg::DELAY_BITS-1:0] chosen_d;
	logic [COUNT_BITS-1:0]           count_a_d;
	logic [COUNT_BITS-1:0]           count_b_d;
	logic [tdrs_pkg::PHASE_BITS-1:0] phase_d;
	logic                            drive_a_d;
	logic                            drive_b_d;
	logic [COUNT_BITS-1:0]           load_val;
	logic [COUNT_BITS-1:0]           dec_a;
	logic [COUNT_BITS-1:0]           dec_b;
	logic                            fall_a;
	logic                            fall_b;
	logic                            rise_b;
	logic                            advance;

	// Handshake: the stage moves when the result slot is free or being taken
	assign advance      = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall   = valid_s1 && !advance;
	assign result_valid = result_valid_q;
	assign result.relay_a = drive_a_q;
	assign result.relay_b = drive_b_q;

	// Write configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_short_q  <= tdrs_pkg::DELAY_SHORT_RST;
			delay_medium_q <= tdrs_pkg::DELAY_MEDIUM_RST;
			delay_long_q   <= tdrs_pkg::DELAY_LONG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tdrs_pkg::REG_DELAY_SHORT:  delay_short_q  <= cfg_data;
				tdrs_pkg::REG_DELAY_MEDIUM: delay_medium_q <= cfg_data;
				tdrs_pkg::REG_DELAY_LONG:   delay_long_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// Edge detection against the last sampled levels
	assign fall_a = !item_s1.level_a && prev_a_q;
	assign fall_b = !item_s1.level_b && prev_b_q;
	assign rise_b = item_s1.level_b && !prev_b_q;

	// Decremented counters, held at zero
	assign dec_a = (count_a_q != '0) ? count_a_q - COUNT_BITS'(1) : count_a_q;
	assign dec_b = (count_b_q != '0) ? count_b_q - COUNT_BITS'(1) : count_b_q;

	// Update logic for one transaction
	always_comb begin
		chosen_d  = chosen_q;
		count_a_d = count_a_q;
		count_b_d = count_b_q;
		phase_d   = phase_q;
		drive_a_d = drive_a_q;
		drive_b_d = drive_b_q;
		load_val  = COUNT_BITS'(chosen_q);

		if (item_s1.action == tdrs_pkg::ACT_TICK) begin
			// Count down; a counter landing on one fires
			count_a_d = dec_a;
			count_b_d = dec_b;
			if (dec_a == COUNT_BITS'(1)) begin
				phase_d = phase_q + tdrs_pkg::PHASE_ONE;
			end
			if (dec_b == COUNT_BITS'(1)) begin
				phase_d   = tdrs_pkg::PHASE_TWO;
				count_a_d = load_val;
			end
		end else begin
			// Select delay, highest key wins
			if (!item_s1.key_one_n) chosen_d = delay_short_q;
			if (!item_s1.key_two_n) chosen_d = delay_medium_q;
			if (!item_s1.key_three_n) chosen_d = delay_long_q;
			load_val = COUNT_BITS'(chosen_d);

			// Edge rules, first match applies
			if (fall_a && item_s1.level_b) begin
				count_a_d = load_val;
				phase_d   = tdrs_pkg::PHASE_IDLE;
			end else if (fall_a) begin
				count_b_d = load_val;
			end else if (fall_b && !item_s1.level_a) begin
				count_b_d = load_val;
			end else if (rise_b && !item_s1.level_a) begin
				phase_d = tdrs_pkg::PHASE_ONE;
			end

			// Relay rules, applied in order
			if (item_s1.level_a) begin
				drive_a_d = 1'b1;
				drive_b_d = 1'b1;
				phase_d   = tdrs_pkg::PHASE_IDLE;
			end
			if (item_s1.level_b) drive_b_d = 1'b1;
			if (!item_s1.level_a && phase_d == tdrs_pkg::PHASE_ONE) drive_a_d = 1'b0;
			if (!item_s1.level_a && !item_s1.level_b) begin
				if (phase_d == tdrs_pkg::PHASE_TWO) begin
					drive_a_d = 1'b1;
					drive_b_d = 1'b0;
				end
				if (phase_d == tdrs_pkg::PHASE_THREE) begin
					drive_a_d = 1'b0;
					drive_b_d = 1'b0;
				end
			end
		end
	end

	// Commit state and hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chosen_q       <= tdrs_pkg::DELAY_LONG_RST;
			count_a_q      <= '0;
			count_b_q      <= '0;
			phase_q        <= tdrs_pkg::PHASE_IDLE;
			prev_a_q       <= 1'b1;
			prev_b_q       <= 1'b1;
			drive_a_q      <= 1'b1;
			drive_b_q      <= 1'b1;
			result_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				chosen_q  <= chosen_d;
				count_a_q <= count_a_d;
				count_b_q <= count_b_d;
				phase_q   <= phase_d;
				drive_a_q <= drive_a_d;
				drive_b_q <= drive_b_d;
				if (item_s1.action == tdrs_pkg::ACT_SAMPLE) begin
					prev_a_q <= item_s1.level_a;
					prev_b_q <= item_s1.level_b;
				end
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule
